// ----- rtl/core/itf_pkg.sv -----
`default_nettype none

package itf_pkg;

  localparam int unsigned NUM_BITS_DEF      = 32;
  localparam int unsigned DIGIT_SLOTS_DEF   = 32;
  localparam int unsigned DIV_BITS_PER_STEP = 8;

  localparam logic [6:0] WIDTH_MAX = 7'd64;
  localparam logic [5:0] PREC_MAX  = 6'd62;
  localparam logic [6:0] MAX_CHARS = 7'd64;
  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;
  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  localparam int unsigned FLAG_ZPAD   = 0;
  localparam int unsigned FLAG_SIGNED = 1;
  localparam int unsigned FLAG_PLUS   = 2;
  localparam int unsigned FLAG_SPACE  = 3;
  localparam int unsigned FLAG_ALT    = 4;
  localparam int unsigned FLAG_LOWER  = 5;
  localparam int unsigned FLAG_LEFT   = 6;

  typedef struct packed {
    logic [31:0] number;
    logic [4:0]  radix;
    logic [6:0]  width;
    logic [5:0]  min_digits;
    logic [6:0]  format_flags;
  } fmt_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } fmt_out_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_PRE0,
    PH_PRE1,
    PH_ZPAD,
    PH_PREC,
    PH_DIGIT,
    PH_TRAIL
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   div_step;
    logic   setup;
    logic   emit;
    phase_e phase;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic div_done;
    logic seg_empty;
    logic seg_end;
    logic last;
  } ctrl_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h41;
      4'd11:   c = 8'h42;
      4'd12:   c = 8'h43;
      4'd13:   c = 8'h44;
      4'd14:   c = 8'h45;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itf_ctrl.sv -----
`default_nettype none

module itf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire itf_pkg::ctrl_sts_t sts_i,
  output itf_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy_o,
  output logic                    valid_o
);
  import itf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   valid_q, valid_d;

  function automatic phase_e next_phase(input phase_e p);
    phase_e n;
    case (p)
      PH_LEAD:  n = PH_SIGN;
      PH_SIGN:  n = PH_PRE0;
      PH_PRE0:  n = PH_PRE1;
      PH_PRE1:  n = PH_ZPAD;
      PH_ZPAD:  n = PH_PREC;
      PH_PREC:  n = PH_DIGIT;
      PH_DIGIT: n = PH_TRAIL;
      default:  n = PH_TRAIL;
    endcase
    return n;
  endfunction

  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    valid_d        = 1'b0;
    cmd_o          = '0;
    cmd_o.phase    = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && sts_i.item_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        phase_d     = PH_LEAD;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.seg_empty) begin
          phase_d = next_phase(phase_q);
        end else begin
          cmd_o.emit = 1'b1;
          valid_d    = 1'b1;
          if (sts_i.last) begin
            state_d = ST_IDLE;
          end else if (sts_i.seg_end) begin
            phase_d = next_phase(phase_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LEAD;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/itf_datapath.sv -----
`default_nettype none

module itf_datapath #(
  parameter int unsigned NUM_BITS    = itf_pkg::NUM_BITS_DEF,
  parameter int unsigned DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire itf_pkg::fmt_in_t    item_i,
  input  wire itf_pkg::ctrl_cmd_t  cmd_i,
  output itf_pkg::ctrl_sts_t       sts_o,
  output itf_pkg::fmt_out_t        result_o
);
  import itf_pkg::*;

  localparam int unsigned BPS   = DIV_BITS_PER_STEP;
  localparam int unsigned STEPS = (NUM_BITS + BPS - 1) / BPS;
  localparam int unsigned QW    = STEPS * BPS;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned AW    = $clog2(DIGIT_SLOTS);
  localparam int unsigned CW    = $clog2(DIGIT_SLOTS + 1);
  localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);
  localparam logic [CW-1:0] SLOTS_C   = CW'(DIGIT_SLOTS);

  logic [QW-1:0]   work_q, work_d;
  logic [3:0]      rem_q, rem_d;
  logic [SW-1:0]   step_q, step_d;
  logic [CW-1:0]   dcnt_q, dcnt_d;
  logic [6:0]      idx_q, idx_d;
  logic [6:0]      ocnt_q, ocnt_d;
  logic [6:0]      pad_q, total_q;
  logic [6:0]      width_q;
  logic [5:0]      prec_q;
  logic [4:0]      radix_q;
  logic [7:0]      sign_char_q;
  logic            has_sign_q;
  logic [1:0]      plen_q;
  logic            lower_q, left_q, zpad_q;
  logic [3:0]      store_q [DIGIT_SLOTS];
  fmt_out_t        res_q;

  // load-time decode
  logic [NUM_BITS-1:0] nb, mag;
  logic                neg;
  logic [7:0]          sign_char;
  logic                has_sign;
  logic [1:0]          plen;
  logic [6:0]          flags;

  always_comb begin
    flags = item_i.format_flags;
    nb    = item_i.number[NUM_BITS-1:0];
    neg   = flags[FLAG_SIGNED] & nb[NUM_BITS-1];
    mag   = neg ? (~nb + 1'b1) : nb;
    has_sign  = 1'b0;
    sign_char = CHAR_SPACE;
    if (flags[FLAG_SIGNED]) begin
      if (neg) begin
        has_sign  = 1'b1;
        sign_char = CHAR_MINUS;
      end else if (flags[FLAG_PLUS]) begin
        has_sign  = 1'b1;
        sign_char = CHAR_PLUS;
      end else if (flags[FLAG_SPACE]) begin
        has_sign  = 1'b1;
        sign_char = CHAR_SPACE;
      end
    end
    plen = 2'd0;
    if (flags[FLAG_ALT]) begin
      if (item_i.radix == RADIX_HEX || item_i.radix == RADIX_BIN) begin
        plen = 2'd2;
      end else if (item_i.radix == RADIX_OCT) begin
        plen = 2'd1;
      end
    end
  end

  // BPS bits of long division per cycle
  logic [BPS-1:0] qbits;
  logic [3:0]     rchain;
  logic [4:0]     trial;
  logic [QW-1:0]  work_n;
  logic           step_last;

  always_comb begin
    rchain = rem_q;
    qbits  = '0;
    trial  = '0;
    for (int i = 0; i < BPS; i++) begin
      trial = {rchain, work_q[QW-1-i]};
      if (trial >= radix_q) begin
        qbits[BPS-1-i] = 1'b1;
        rchain         = 4'(trial - radix_q);
      end else begin
        rchain = trial[3:0];
      end
    end
    work_n    = (work_q << BPS) | QW'(qbits);
    step_last = (step_q == STEP_LAST);
  end

  // segment lengths and characters
  logic [6:0] dcnt7, prec7, body7, used7, tot7;
  logic [6:0] seg_len;
  logic [7:0] seg_char;
  logic [AW-1:0] rd_idx;

  always_comb begin
    dcnt7  = 7'(dcnt_q);
    prec7  = {1'b0, prec_q};
    body7  = (dcnt7 > prec7) ? dcnt7 : prec7;
    used7  = 7'(has_sign_q) + 7'(plen_q) + body7;
    tot7   = (width_q > used7) ? width_q : used7;
    rd_idx = AW'(dcnt7 - 7'd1 - idx_q);
    case (cmd_i.phase)
      PH_LEAD: begin
        seg_len  = (!zpad_q && !left_q) ? pad_q : 7'd0;
        seg_char = CHAR_SPACE;
      end
      PH_SIGN: begin
        seg_len  = 7'(has_sign_q);
        seg_char = sign_char_q;
      end
      PH_PRE0: begin
        seg_len  = 7'(plen_q != 2'd0);
        seg_char = CHAR_ZERO;
      end
      PH_PRE1: begin
        seg_len  = 7'(plen_q == 2'd2);
        seg_char = (radix_q == RADIX_HEX) ? (CHAR_X | (lower_q ? CASE_BIT : 8'h00)) : CHAR_B;
      end
      PH_ZPAD: begin
        seg_len  = zpad_q ? pad_q : 7'd0;
        seg_char = CHAR_ZERO;
      end
      PH_PREC: begin
        seg_len  = (prec7 > dcnt7) ? (prec7 - dcnt7) : 7'd0;
        seg_char = CHAR_ZERO;
      end
      PH_DIGIT: begin
        seg_len  = dcnt7;
        seg_char = digit_char(store_q[rd_idx]) | (lower_q ? CASE_BIT : 8'h00);
      end
      default: begin
        seg_len  = left_q ? pad_q : 7'd0;
        seg_char = CHAR_SPACE;
      end
    endcase
  end

  assign sts_o.item_ok   = (item_i.radix >= RADIX_MIN) && (item_i.radix <= RADIX_MAX);
  assign sts_o.div_done  = step_last && ((work_n == '0) || (dcnt_q + 1'b1 == SLOTS_C));
  assign sts_o.seg_empty = (seg_len == 7'd0);
  assign sts_o.seg_end   = (idx_q + 7'd1 == seg_len);
  assign sts_o.last      = (ocnt_q + 7'd1 == total_q);

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    step_d = step_q;
    dcnt_d = dcnt_q;
    idx_d  = idx_q;
    ocnt_d = ocnt_q;
    if (cmd_i.load) begin
      work_d = QW'(mag);
      rem_d  = '0;
      step_d = '0;
      dcnt_d = '0;
      idx_d  = '0;
      ocnt_d = '0;
    end else if (cmd_i.div_step) begin
      work_d = work_n;
      if (step_last) begin
        rem_d  = '0;
        step_d = '0;
        dcnt_d = dcnt_q + 1'b1;
      end else begin
        rem_d  = rchain;
        step_d = step_q + 1'b1;
      end
    end else if (cmd_i.emit) begin
      ocnt_d = ocnt_q + 7'd1;
      idx_d  = sts_o.seg_end ? 7'd0 : (idx_q + 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      step_q <= '0;
      dcnt_q <= '0;
      idx_q  <= '0;
      ocnt_q <= '0;
    end else begin
      rem_q  <= rem_d;
      step_q <= step_d;
      dcnt_q <= dcnt_d;
      idx_q  <= idx_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (cmd_i.load) begin
      radix_q     <= item_i.radix;
      width_q     <= (item_i.width > WIDTH_MAX) ? WIDTH_MAX : item_i.width;
      prec_q      <= (item_i.min_digits > PREC_MAX) ? PREC_MAX : item_i.min_digits;
      sign_char_q <= sign_char;
      has_sign_q  <= has_sign;
      plen_q      <= plen;
      lower_q     <= flags[FLAG_LOWER];
      left_q      <= flags[FLAG_LEFT];
      zpad_q      <= flags[FLAG_ZPAD] & ~flags[FLAG_LEFT];
    end
    if (cmd_i.div_step && step_last) begin
      store_q[dcnt_q[AW-1:0]] <= rchain;
    end
    if (cmd_i.setup) begin
      pad_q   <= (width_q > used7) ? (width_q - used7) : 7'd0;
      total_q <= (tot7 > MAX_CHARS) ? MAX_CHARS : tot7;
    end
    if (cmd_i.emit) begin
      res_q.character <= seg_char;
      res_q.last      <= sts_o.last;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_text_formatter_top.sv -----
// Integer to text formatter: printf-style conversion of one integer.
// Input: item_i carries number, radix (2..16), width, min_digits and
// format_flags. An item is taken at a rising edge with start_i high and
// busy_o low; busy_o stays high until the item's last character is out.
// An item with a radix outside 2..16 is dropped and produces no output.
// Output: one ASCII character per cycle on result_o, save where an empty
// text segment is passed, each marked by result_valid_o for exactly one
// cycle; result_o.last flags the final one. The receiver cannot stall;
// every strobed character must be taken.
// Flow per item: a load step, then the digit loop runs a shared
// long-division unit that retires 8 quotient bits a cycle, repeated for
// every digit (1 to DIGIT_SLOTS). Then a setup step, then the emit phase
// walks the text segments in order: at most 64 characters and at most 6
// empty segments, which give no strobe. Example: 32-bit decimal
// 4294967295 runs the division loop for ten digits. After setup, the
// empty segments ahead of the first character are passed before it is emitted.
// Reset: asynchronous, active low; the block returns idle with no strobe.
`default_nettype none

module integer_to_text_formatter_top #(
  parameter int unsigned NUM_BITS    = itf_pkg::NUM_BITS_DEF,
  parameter int unsigned DIGIT_SLOTS = itf_pkg::DIGIT_SLOTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire itf_pkg::fmt_in_t  item_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output itf_pkg::fmt_out_t      result_o
);
  import itf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  itf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (result_valid_o)
  );

  itf_datapath #(
    .NUM_BITS    (NUM_BITS),
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ----- verif/itf_text_checker.sv -----
`default_nettype none

module itf_text_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire itf_pkg::fmt_in_t  item_i,
  input  wire logic              result_valid_i,
  input  wire itf_pkg::fmt_out_t result_i,
  output int unsigned            mismatch_count_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import itf_pkg::*;

  fmt_out_t expected_text[$];

  function automatic logic [7:0] digit_to_char(input logic [3:0] d);
    // letters start at 'A'
    return (d < 4'd10) ? (CHAR_ZERO + 8'(d)) : (8'h37 + 8'(d));
  endfunction

  function automatic void predict_text(input fmt_in_t it);
    logic [3:0]  digits[32];
    logic [7:0]  txt[$];
    logic [31:0] mag;
    logic [7:0]  sign_ch;
    logic [7:0]  lower;
    logic [6:0]  f;
    logic        left, zpad, has_sign;
    int unsigned rdx, fw, prec, plen, ndig, body, used, pad, n;
    fmt_out_t    r;
    rdx = it.radix;
    if (rdx < RADIX_MIN || rdx > RADIX_MAX) return;
    fw   = (it.width > WIDTH_MAX) ? WIDTH_MAX : it.width;
    prec = (it.min_digits > PREC_MAX) ? PREC_MAX : it.min_digits;
    f     = it.format_flags;
    lower = f[FLAG_LOWER] ? CASE_BIT : 8'h00;
    left  = f[FLAG_LEFT];
    zpad  = f[FLAG_ZPAD] && !left;

    mag      = it.number;
    has_sign = 1'b0;
    sign_ch  = CHAR_SPACE;
    if (f[FLAG_SIGNED]) begin
      if (mag[31]) begin
        has_sign = 1'b1;
        sign_ch  = CHAR_MINUS;
        mag      = -mag;
      end else if (f[FLAG_PLUS]) begin
        has_sign = 1'b1;
        sign_ch  = CHAR_PLUS;
      end else if (f[FLAG_SPACE]) begin
        has_sign = 1'b1;
        sign_ch  = CHAR_SPACE;
      end
    end

    plen = 0;
    if (f[FLAG_ALT]) begin
      if (it.radix == RADIX_HEX || it.radix == RADIX_BIN) plen = 2;
      else if (it.radix == RADIX_OCT) plen = 1;
    end

    ndig = 0;
    if (mag == 32'd0) begin
      digits[0] = 4'd0;
      ndig = 1;
    end else begin
      while (mag != 32'd0 && ndig < 32) begin
        digits[ndig] = 4'(mag % rdx);
        mag = mag / rdx;
        ndig++;
      end
    end

    body = (ndig > prec) ? ndig : prec;
    used = (has_sign ? 1 : 0) + plen + body;
    pad  = (fw > used) ? fw - used : 0;

    if (!zpad && !left) repeat (pad) txt.push_back(CHAR_SPACE);
    if (has_sign) txt.push_back(sign_ch);
    if (plen >= 1) txt.push_back(CHAR_ZERO);
    if (plen == 2) txt.push_back((it.radix == RADIX_HEX) ? (CHAR_X | lower) : CHAR_B);
    if (zpad) repeat (pad) txt.push_back(CHAR_ZERO);
    repeat (body - ndig) txt.push_back(CHAR_ZERO);
    for (int k = ndig; k > 0; k--) txt.push_back(digit_to_char(digits[k-1]) | lower);
    if (left) repeat (pad) txt.push_back(CHAR_SPACE);

    n = (txt.size() > MAX_CHARS) ? MAX_CHARS : txt.size();
    for (int k = 0; k < n; k++) begin
      r.character = txt[k];
      r.last      = (k == n - 1);
      expected_text.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fmt_out_t want;
    if (!rst_ni) begin
      expected_text.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_text.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("%0t: unexpected character 8'h%h last %b", $realtime,
                     result_i.character, result_i.last);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_text.pop_front();
          if (want.character !== result_i.character || want.last !== result_i.last) begin
            if (mismatch_count_o < 10)
              $display("%0t: expected char 8'h%h last %b, got char 8'h%h last %b",
                       $realtime, want.character, want.last,
                       result_i.character, result_i.last);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i) predict_text(item_i);
      pending_o <= expected_text.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import itf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned QUIET_TAIL   = 100;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam logic [6:0] FL_ZPAD   = 7'(1 << FLAG_ZPAD);
  localparam logic [6:0] FL_SIGNED = 7'(1 << FLAG_SIGNED);
  localparam logic [6:0] FL_PLUS   = 7'(1 << FLAG_PLUS);
  localparam logic [6:0] FL_SPACE  = 7'(1 << FLAG_SPACE);
  localparam logic [6:0] FL_ALT    = 7'(1 << FLAG_ALT);
  localparam logic [6:0] FL_LOWER  = 7'(1 << FLAG_LOWER);
  localparam logic [6:0] FL_LEFT   = 7'(1 << FLAG_LEFT);

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start_i = 1'b0;
  fmt_in_t     item_i  = '0;
  logic        busy_o;
  logic        result_valid_o;
  fmt_out_t    result_o;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  integer_to_text_formatter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  itf_text_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .item_i           (item_i),
    .result_valid_i   (result_valid_o),
    .result_i         (result_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  function automatic fmt_in_t mk(input logic [31:0] num, input logic [4:0] rdx,
                                 input logic [6:0] fw, input logic [5:0] prec,
                                 input logic [6:0] flags);
    fmt_in_t it;
    it.number       = num;
    it.radix        = rdx;
    it.width        = fw;
    it.min_digits   = prec;
    it.format_flags = flags;
    return it;
  endfunction

  function automatic fmt_in_t random_number_item();
    fmt_in_t it;
    case ($urandom_range(0, 5))
      0:       it.number = $urandom_range(0, 999);
      1:       it.number = -$urandom_range(1, 999);
      2: begin
        case ($urandom_range(0, 4))
          0:       it.number = 32'h0;
          1:       it.number = 32'h7FFF_FFFF;
          2:       it.number = 32'h8000_0000;
          3:       it.number = 32'h0000_0001;
          default: it.number = 32'hFFFF_FFFF;
        endcase
      end
      default: it.number = $urandom;
    endcase
    if ($urandom_range(0, 15) == 0)
      it.radix = $urandom_range(0, 1) ? 5'($urandom_range(0, 1)) : 5'($urandom_range(17, 31));
    else begin
      case ($urandom_range(0, 5))
        0:       it.radix = RADIX_BIN;
        1:       it.radix = RADIX_OCT;
        2:       it.radix = RADIX_HEX;
        3:       it.radix = 5'd10;
        default: it.radix = 5'($urandom_range(2, 16));
      endcase
    end
    it.width        = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(0, 24));
    it.min_digits   = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 12));
    it.format_flags = 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic issue_number(input fmt_in_t it, input bit allow_gap);
    int unsigned gap;
    gap = 0;
    if (allow_gap && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    fmt_in_t directed[$];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(mk(32'd0, 5'd10, 7'd0, 6'd0, 7'h00));
    directed.push_back(mk(32'd0, RADIX_HEX, 7'd0, 6'd5, FL_ALT));
    directed.push_back(mk(32'hFFFF_FFFF, RADIX_BIN, 7'd0, 6'd0, FL_ALT));
    directed.push_back(mk(32'hFFFF_FFFF, 5'd10, 7'd0, 6'd0, 7'h00));
    directed.push_back(mk(32'h8000_0000, 5'd10, 7'd0, 6'd0, FL_SIGNED));
    directed.push_back(mk(32'hFFFF_FFFF, RADIX_HEX, 7'd0, 6'd0, FL_SIGNED | FL_ALT | FL_LOWER));
    directed.push_back(mk(32'd123, 5'd10, 7'd0, 6'd0, FL_SIGNED | FL_PLUS));
    directed.push_back(mk(32'd123, 5'd10, 7'd6, 6'd0, FL_SIGNED | FL_SPACE));
    directed.push_back(mk(32'd123, 5'd10, 7'd6, 6'd0, FL_PLUS | FL_SPACE));
    directed.push_back(mk(32'h7FFF_FFFF, 5'd10, 7'd127, 6'd0, FL_SIGNED | FL_PLUS));
    directed.push_back(mk(32'hDEAD_BEEF, RADIX_HEX, 7'd64, 6'd0,
                          FL_LEFT | FL_ZPAD | FL_ALT | FL_LOWER));
    directed.push_back(mk(32'hFFFF_FF85, RADIX_HEX, 7'd20, 6'd0, FL_ZPAD | FL_SIGNED | FL_ALT));
    // sign, prefix and 62 digits overflow the 64-character limit
    directed.push_back(mk(32'h8000_0001, RADIX_HEX, 7'd0, 6'd63, FL_SIGNED | FL_ALT));
    directed.push_back(mk(32'd511, RADIX_OCT, 7'd10, 6'd0, FL_ALT | FL_ZPAD));
    directed.push_back(mk(32'h00AB_CDEF, RADIX_HEX, 7'd0, 6'd0, FL_LOWER));
    directed.push_back(mk(32'd1234567, 5'd3, 7'd0, 6'd0, FL_ALT));
    directed.push_back(mk(32'd98765, 5'd7, 7'd4, 6'd8, FL_LEFT));
    directed.push_back(mk(32'hFEDC_BA98, 5'd13, 7'd0, 6'd0, FL_LOWER));
    directed.push_back(mk(32'd42, 5'd0, 7'd5, 6'd0, 7'h00));
    directed.push_back(mk(32'd42, 5'd1, 7'd5, 6'd0, 7'h00));
    directed.push_back(mk(32'd42, 5'd17, 7'd5, 6'd0, 7'h00));
    directed.push_back(mk(32'd42, 5'd31, 7'd5, 6'd0, 7'h00));
    directed.push_back(mk(32'h5A5A_5A5A, RADIX_HEX, 7'd64, 6'd62, 7'h7F));
    directed.push_back(mk(32'h1234_5678, 5'd5, 7'd30, 6'd10, FL_ZPAD | FL_SIGNED | FL_SPACE));
    directed.push_back(mk(32'd0, RADIX_BIN, 7'd1, 6'd0, FL_SIGNED | FL_PLUS | FL_ALT));

    foreach (directed[i]) issue_number(directed[i], 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      issue_number(random_number_item(), i < RANDOM_ITEMS - QUIET_TAIL);

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
